FILE: src/assert_macros.svh
// Shared assertion forms for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PWAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwam assertion failed");

// Next-cycle implication.
`define PWAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwam assertion failed");

`endif

FILE: src/pwam_pkg.sv
package pwam_pkg;

    localparam int NPIX_DEFAULT      = 4096;
    localparam int ACC_WIDTH_DEFAULT = 48;

    localparam int PIXEL_W   = 12;
    localparam int HIT_W     = 20;
    localparam int WEIGHT_W  = 16;
    localparam int TRIG_W    = 16;
    localparam int DET_OUT_W = 64;
    localparam int THR_W     = 63;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 13;
    localparam int INDEX_W   = 12;
    localparam int OP_W      = 2;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 63;

    localparam int SMUL_A_W = 33;
    localparam int SMUL_P_W = 49;
    localparam int DELTA_W  = 28;

    localparam int STEP_W  = 4;
    localparam int SSTEP_W = 3;
    localparam logic [SSTEP_W-1:0] SSTEP_LAST = 3'd4;

    localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] CFG_SOLVER_MODE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DET_THRESHOLD = 1'b1;

    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_I    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QU   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_IQU  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_IQU;

    typedef enum logic [OP_W-1:0] {
        OP_ACCUM   = 2'd0,
        OP_EVAL    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        SRC_N, SRC_S, SRC_C, SRC_SS, SRC_CC, SRC_SC, SRC_TMP
    } src_t;

    typedef enum logic [2:0] {
        DST_TMP, DST_SET, DST_ADD, DST_ADD2, DST_SUB
    } dst_t;

    typedef struct packed {
        src_t src_a;
        src_t src_b;
        dst_t dst;
        logic last;
    } det_op_t;

    typedef enum logic [2:0] {
        SM_WS, SM_WC, SM_WSS, SM_WCC, SM_WSC
    } smul_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_ACC_RD, ST_ACC_MUL, ST_ACC_WR,
        ST_EV_RD, ST_EV_LOAD, ST_EV_MSTART, ST_EV_MWAIT, ST_EV_FIN, ST_EV_OUT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     clr_wr;
        logic     rd;
        logic     acc_wr;
        logic     smul_en;
        smul_op_t smul_op;
        logic     mul_start;
        logic     det_apply;
        det_op_t  det_op;
        logic     fin_det;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        op_t               op;
        logic              in_range;
        logic [MODE_W-1:0] mode;
        logic              mul_done;
        logic              clr_last;
        logic              out_free;
    } status_t;

    function automatic det_op_t det_program(input logic [MODE_W-1:0] mode,
                                            input logic [STEP_W-1:0] step);
        det_op_t r;
        r = '{SRC_SC, SRC_SC, DST_SUB, 1'b1};
        if (mode == MODE_QU)
        begin
            unique case (step)
                4'd0:    r = '{SRC_SS, SRC_CC, DST_SET, 1'b0};
                default: r = '{SRC_SC, SRC_SC, DST_SUB, 1'b1};
            endcase
        end
        else
        begin
            unique case (step)
                4'd0:    r = '{SRC_N,   SRC_CC, DST_TMP,  1'b0};
                4'd1:    r = '{SRC_TMP, SRC_SS, DST_SET,  1'b0};
                4'd2:    r = '{SRC_C,   SRC_S,  DST_TMP,  1'b0};
                4'd3:    r = '{SRC_TMP, SRC_SC, DST_ADD2, 1'b0};
                4'd4:    r = '{SRC_N,   SRC_SC, DST_TMP,  1'b0};
                4'd5:    r = '{SRC_TMP, SRC_SC, DST_SUB,  1'b0};
                4'd6:    r = '{SRC_C,   SRC_C,  DST_TMP,  1'b0};
                4'd7:    r = '{SRC_TMP, SRC_SS, DST_SUB,  1'b0};
                4'd8:    r = '{SRC_S,   SRC_S,  DST_TMP,  1'b0};
                default: r = '{SRC_TMP, SRC_CC, DST_SUB,  1'b1};
            endcase
        end
        return r;
    endfunction

endpackage

FILE: src/pwam_mul.sv
module pwam_mul
    import pwam_pkg::*;
#(
    parameter int A_W = 2 * ACC_WIDTH_DEFAULT,
    parameter int B_W = ACC_WIDTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [A_W-1:0]       a,
    input  logic signed [B_W-1:0]       b,
    output logic                        done,
    output logic signed [A_W+B_W-1:0]   product
);

    localparam int P_W   = A_W + B_W;
    localparam int NDIG  = (B_W + 7) / 8;
    localparam int BX_W  = NDIG * 8;
    localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic signed [P_W-1:0]  mcand_reg;
    logic [BX_W-1:0]        mplier_reg;
    logic signed [P_W-1:0]  acc_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [7:0]             digit;
    logic                   last;
    logic signed [8:0]      dsig;
    logic signed [P_W-1:0]  pp;

    assign digit = mplier_reg[7:0];
    assign last  = (cnt_reg == CNT_W'(NDIG - 1));
    assign dsig  = last ? {digit[7], digit} : {1'b0, digit};
    assign pp    = mcand_reg * dsig;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= P_W'(a);
            mplier_reg <= BX_W'(b);
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg    <= acc_reg + pp;
            mcand_reg  <= mcand_reg <<< 8;
            mplier_reg <= mplier_reg >> 8;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: src/pwam_datapath.sv
module pwam_datapath
    import pwam_pkg::*;
#(
    parameter int NPIX      = NPIX_DEFAULT,
    parameter int ACC_WIDTH = ACC_WIDTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [OP_W-1:0]               operation,
    input  logic [PIXEL_W-1:0]            pixel,
    input  logic                          sample_valid,
    input  logic [WEIGHT_W-1:0]           noise_weight,
    input  logic signed [TRIG_W-1:0]      sin_two_phi,
    input  logic signed [TRIG_W-1:0]      cos_two_phi,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  cmd_t                          cmd,
    output status_t                       status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [PIXEL_W-1:0]            pixel_echo,
    output logic signed [DET_OUT_W-1:0]   determinant,
    output logic [HIT_W-1:0]              hit_total,
    output logic                          observed,
    output logic [INDEX_W-1:0]            compact_index
);

    localparam int W      = ACC_WIDTH;
    localparam int SW     = W + 1;
    localparam int AW2    = 2 * W;
    localparam int PW     = 3 * W;
    localparam int DET_W  = 3 * W + 3;
    localparam int ADDR_W = $clog2(NPIX);
    localparam int ROW_W  = HIT_W + 6 * W;

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [DELTA_W-1:0] d);
        logic signed [SW-1:0] s;
        s = SW'(a) + SW'(d);
        if (s[SW-1] != s[SW-2])
            sat_add = s[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            sat_add = s[W-1:0];
    endfunction

    op_t                        op_reg;
    logic [PIXEL_W-1:0]         pixel_reg;
    logic                       sval_reg;
    logic [WEIGHT_W-1:0]        weight_reg;
    logic signed [TRIG_W-1:0]   sin_reg;
    logic signed [TRIG_W-1:0]   cos_reg;

    logic [MODE_W-1:0]          mode_reg;
    logic [THR_W-1:0]           thr_reg;
    logic [MODE_W-1:0]          mode_eff;

    logic [ROW_W-1:0]           mem [NPIX];
    logic [ROW_W-1:0]           rd_data_reg;
    logic [ADDR_W-1:0]          addr;
    logic [ADDR_W-1:0]          clr_addr_reg;
    logic                       clr_last;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ROW_W-1:0]           wr_data;
    logic [ROW_W-1:0]           new_row;
    logic                       in_range;

    logic [HIT_W-1:0]           f_hit;
    logic signed [W-1:0]        f_n, f_s, f_c, f_ss, f_cc, f_sc;
    logic [HIT_W-1:0]           new_hit;

    logic signed [WEIGHT_W:0]   w17;
    logic signed [SMUL_A_W-1:0] smul_a;
    logic signed [TRIG_W-1:0]   smul_b;
    logic signed [SMUL_P_W-1:0] smul_p;
    logic signed [SMUL_A_W-1:0] ws_reg, wc_reg;
    logic signed [SMUL_P_W-1:0] wss_reg, wcc_reg, wsc_reg;
    logic signed [DELTA_W-1:0]  d_n, d_s, d_c, d_ss, d_cc, d_sc;

    logic signed [AW2-1:0]      mul_a;
    logic signed [W-1:0]        mul_b;
    logic signed [PW-1:0]       mul_p;
    logic                       mul_done;
    logic signed [AW2-1:0]      tmp_reg;
    logic signed [DET_W-1:0]    acc_reg;
    logic signed [DET_W-1:0]    prod_ext;
    logic signed [DET_W-1:0]    sh_acc;
    logic                       sat_ok;
    logic signed [DET_OUT_W-1:0] det_sat;
    logic signed [DET_OUT_W-1:0] det_next;
    logic signed [DET_OUT_W-1:0] det_reg;
    logic [DET_OUT_W-1:0]       mag;
    logic                       obs_next;

    logic [COUNT_W-1:0]         count_reg;
    logic                       out_valid_reg;
    logic [PIXEL_W-1:0]         out_pixel_reg;
    logic signed [DET_OUT_W-1:0] out_det_reg;
    logic [HIT_W-1:0]           out_hit_reg;
    logic                       out_obs_reg;
    logic [INDEX_W-1:0]         out_cidx_reg;

    // capture transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op_t'(operation);
            pixel_reg  <= pixel;
            sval_reg   <= sample_valid;
            weight_reg <= noise_weight;
            sin_reg    <= sin_two_phi;
            cos_reg    <= cos_two_phi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            thr_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SOLVER_MODE:   mode_reg <= cfg_data[MODE_W-1:0];
                CFG_DET_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                default:           ;
            endcase
        end
    end

    assign mode_eff = (mode_reg == MODE_ZERO) ? MODE_I : mode_reg;
    assign in_range = (32'(pixel_reg) < 32'(NPIX));
    assign addr     = ADDR_W'(pixel_reg);
    assign clr_last = (clr_addr_reg == ADDR_W'(NPIX - 1));

    assign wr_en   = cmd.clr_wr | cmd.acc_wr;
    assign wr_addr = cmd.clr_wr ? clr_addr_reg : addr;
    assign wr_data = cmd.clr_wr ? '0 : new_row;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd)
            rd_data_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_wr)
            clr_addr_reg <= clr_last ? '0 : clr_addr_reg + 1'b1;
    end

    assign f_hit = rd_data_reg[ROW_W-1 -: HIT_W];
    assign f_n   = rd_data_reg[6*W-1 -: W];
    assign f_s   = rd_data_reg[5*W-1 -: W];
    assign f_c   = rd_data_reg[4*W-1 -: W];
    assign f_ss  = rd_data_reg[3*W-1 -: W];
    assign f_cc  = rd_data_reg[2*W-1 -: W];
    assign f_sc  = rd_data_reg[W-1:0];

    // sample products, one per cycle
    assign w17 = {1'b0, (sval_reg ? weight_reg : {WEIGHT_W{1'b0}})};

    always_comb
    begin
        case (cmd.smul_op) inside
            SM_WS, SM_WC:   smul_a = SMUL_A_W'(w17);
            SM_WSS, SM_WSC: smul_a = ws_reg;
            SM_WCC:         smul_a = wc_reg;
            default:        smul_a = '0;
        endcase
        case (cmd.smul_op) inside
            SM_WS, SM_WSS:  smul_b = sin_reg;
            default:        smul_b = cos_reg;
        endcase
    end

    assign smul_p = smul_a * smul_b;

    always_ff @(posedge clk)
    begin
        if (cmd.smul_en)
        begin
            case (cmd.smul_op)
                SM_WS:   ws_reg  <= smul_p[SMUL_A_W-1:0];
                SM_WC:   wc_reg  <= smul_p[SMUL_A_W-1:0];
                SM_WSS:  wss_reg <= smul_p;
                SM_WCC:  wcc_reg <= smul_p;
                SM_WSC:  wsc_reg <= smul_p;
                default: ;
            endcase
        end
    end

    assign d_n  = DELTA_W'({w17, 8'd0});
    assign d_s  = DELTA_W'(ws_reg >>> 7);
    assign d_c  = DELTA_W'(wc_reg >>> 7);
    assign d_ss = DELTA_W'(wss_reg >>> 22);
    assign d_cc = DELTA_W'(wcc_reg >>> 22);
    assign d_sc = DELTA_W'(wsc_reg >>> 22);

    assign new_hit = f_hit + HIT_W'(sval_reg && (f_hit != HIT_MAX));
    assign new_row = {new_hit, sat_add(f_n, d_n), sat_add(f_s, d_s), sat_add(f_c, d_c),
                      sat_add(f_ss, d_ss), sat_add(f_cc, d_cc), sat_add(f_sc, d_sc)};

    // determinant products
    always_comb
    begin
        case (cmd.det_op.src_a)
            SRC_N:   mul_a = AW2'(f_n);
            SRC_S:   mul_a = AW2'(f_s);
            SRC_C:   mul_a = AW2'(f_c);
            SRC_SS:  mul_a = AW2'(f_ss);
            SRC_CC:  mul_a = AW2'(f_cc);
            SRC_SC:  mul_a = AW2'(f_sc);
            default: mul_a = tmp_reg;
        endcase
        case (cmd.det_op.src_b)
            SRC_N:   mul_b = f_n;
            SRC_S:   mul_b = f_s;
            SRC_C:   mul_b = f_c;
            SRC_SS:  mul_b = f_ss;
            SRC_CC:  mul_b = f_cc;
            SRC_SC:  mul_b = f_sc;
            default: mul_b = '0;
        endcase
    end

    pwam_mul #(
        .A_W (AW2),
        .B_W (W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign prod_ext = DET_W'(mul_p);

    always_ff @(posedge clk)
    begin
        if (cmd.det_apply)
        begin
            case (cmd.det_op.dst)
                DST_TMP:  tmp_reg <= mul_p[AW2-1:0];
                DST_SET:  acc_reg <= prod_ext;
                DST_ADD:  acc_reg <= acc_reg + prod_ext;
                DST_ADD2: acc_reg <= acc_reg + (prod_ext <<< 1);
                DST_SUB:  acc_reg <= acc_reg - prod_ext;
                default:  ;
            endcase
        end
    end

    assign sh_acc  = (mode_eff == MODE_QU) ? (acc_reg >>> 16) : (acc_reg >>> 32);
    assign sat_ok  = (&sh_acc[DET_W-1:DET_OUT_W-1]) | ~(|sh_acc[DET_W-1:DET_OUT_W-1]);
    assign det_sat = sat_ok ? sh_acc[DET_OUT_W-1:0] :
                     (sh_acc[DET_W-1] ? {1'b1, {(DET_OUT_W-1){1'b0}}}
                                      : {1'b0, {(DET_OUT_W-1){1'b1}}});

    always_comb
    begin
        if (!in_range)
            det_next = '0;
        else if (mode_eff == MODE_I)
            det_next = DET_OUT_W'(f_n);
        else
            det_next = det_sat;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_det)
            det_reg <= det_next;
    end

    assign mag      = det_reg[DET_OUT_W-1] ? (~det_reg + 1'b1) : det_reg;
    assign obs_next = in_range && (mag > {1'b0, thr_reg}) && (f_hit >= HIT_W'(mode_eff));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
                count_reg <= '0;
            else if (cmd.out_load && obs_next)
                count_reg <= count_reg + 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pixel_reg <= pixel_reg;
            out_det_reg   <= det_reg;
            out_hit_reg   <= in_range ? f_hit : '0;
            out_obs_reg   <= obs_next;
            out_cidx_reg  <= obs_next ? count_reg[INDEX_W-1:0] : '0;
        end
    end

    assign status.op       = op_reg;
    assign status.in_range = in_range;
    assign status.mode     = mode_eff;
    assign status.mul_done = mul_done;
    assign status.clr_last = clr_last;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign pixel_echo    = out_pixel_reg;
    assign determinant   = out_det_reg;
    assign hit_total     = out_hit_reg;
    assign observed      = out_obs_reg;
    assign compact_index = out_cidx_reg;

endmodule

FILE: src/pwam_ctrl.sv
module pwam_ctrl
    import pwam_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t               state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [SSTEP_W-1:0]   sstep_reg, sstep_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
            sstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sstep_reg <= sstep_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sstep_next = sstep_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.det_op = det_program(status.mode, step_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (status.op)
                    OP_ACCUM:   state_next = status.in_range ? ST_ACC_RD : ST_IDLE;
                    OP_EVAL:    state_next = ST_EV_RD;
                    OP_RESTART: state_next = ST_CLEAR;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_ACC_RD:
            begin
                cmd.rd      = 1'b1;
                cmd.smul_en = 1'b1;
                cmd.smul_op = SM_WS;
                sstep_next  = SSTEP_W'(1);
                state_next  = ST_ACC_MUL;
            end
            ST_ACC_MUL:
            begin
                cmd.smul_en = 1'b1;
                unique case (sstep_reg)
                    3'd1:    cmd.smul_op = SM_WC;
                    3'd2:    cmd.smul_op = SM_WSS;
                    3'd3:    cmd.smul_op = SM_WCC;
                    default: cmd.smul_op = SM_WSC;
                endcase
                if (sstep_reg == SSTEP_LAST)
                    state_next = ST_ACC_WR;
                else
                    sstep_next = sstep_reg + 1'b1;
            end
            ST_ACC_WR:
            begin
                cmd.acc_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EV_RD:
            begin
                cmd.rd     = 1'b1;
                step_next  = '0;
                state_next = ST_EV_LOAD;
            end
            ST_EV_LOAD:
            begin
                if (!status.in_range || status.mode == MODE_I)
                    state_next = ST_EV_FIN;
                else
                    state_next = ST_EV_MSTART;
            end
            ST_EV_MSTART:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_EV_MWAIT;
            end
            ST_EV_MWAIT:
            begin
                if (status.mul_done)
                begin
                    cmd.det_apply = 1'b1;
                    if (cmd.det_op.last)
                        state_next = ST_EV_FIN;
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        state_next = ST_EV_MSTART;
                    end
                end
            end
            ST_EV_FIN:
            begin
                cmd.fin_det = 1'b1;
                state_next  = ST_EV_OUT;
            end
            ST_EV_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/pixel_weight_accumulate_and_mask_top.sv
// Per-pixel pointing weight accumulator with observation mask.
// Input channel (in_valid/in_ready) carries one transaction: accumulate a
// sample, evaluate a pixel, or restart. Only evaluate produces a result on
// the output channel (out_valid/out_ready). Configuration is written through
// cfg_write/cfg_index/cfg_data while the block is idle.
// One transaction is handled at a time; the accumulator row lives in a single
// memory with one read and one write port.
// Accumulate: dispatch, row read, five products through a shared
// 33x16 multiplier, row write.
// Evaluate: QU and IQU add 2 and 10 wide products on a digit-serial multiplier.
// Restart: clearing pass over all NPIX rows, one row a cycle.
// After reset the same clearing pass runs with in_ready low.
// A finished result sits in an output register; the next transaction is
// accepted while it waits, and a further evaluate holds at its final step
// until out_ready frees the register.
module pixel_weight_accumulate_and_mask_top
    import pwam_pkg::*;
#(
    parameter int NPIX      = NPIX_DEFAULT,
    parameter int ACC_WIDTH = ACC_WIDTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [OP_W-1:0]               operation,
    input  logic [PIXEL_W-1:0]            pixel,
    input  logic                          sample_valid,
    input  logic [WEIGHT_W-1:0]           noise_weight,
    input  logic signed [TRIG_W-1:0]      sin_two_phi,
    input  logic signed [TRIG_W-1:0]      cos_two_phi,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [PIXEL_W-1:0]            pixel_echo,
    output logic signed [DET_OUT_W-1:0]   determinant,
    output logic [HIT_W-1:0]              hit_total,
    output logic                          observed,
    output logic [INDEX_W-1:0]            compact_index,
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    cmd_t    cmd;
    status_t status;

    pwam_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pwam_datapath #(
        .NPIX      (NPIX),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (operation),
        .pixel         (pixel),
        .sample_valid  (sample_valid),
        .noise_weight  (noise_weight),
        .sin_two_phi   (sin_two_phi),
        .cos_two_phi   (cos_two_phi),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_echo    (pixel_echo),
        .determinant   (determinant),
        .hit_total     (hit_total),
        .observed      (observed),
        .compact_index (compact_index)
    );

endmodule

FILE: src/pwam_checker.sv
`include "assert_macros.svh"

module pwam_checker
    import pwam_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [DET_OUT_W-1:0] determinant,
    input logic [HIT_W-1:0]            hit_total,
    input logic                        observed,
    input logic [INDEX_W-1:0]          compact_index
);

    `PWAM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `PWAM_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(determinant) && $stable(compact_index))
    `PWAM_ASSERT_IMP(a_index_unobserved, clk, rst_n, out_valid && !observed, compact_index == '0)
    `PWAM_ASSERT_IMP(a_observed_hits, clk, rst_n, out_valid && observed, hit_total != '0)
    `PWAM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind pixel_weight_accumulate_and_mask_top pwam_checker u_checker (.*);
